// File: sv/b32d_pkg.sv
// Shared types for the base32 text-to-integer decoder.
// Holds the symbol class carried from the byte decoder to the accumulator,
// the status codes and the result width codes. Depends on nothing.
`default_nettype none

package b32d_pkg;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_RANGE   = 2'd2
  } status_t;

  localparam logic [1:0] WIDTH_16 = 2'd0;
  localparam logic [1:0] WIDTH_32 = 2'd1;
  localparam logic [1:0] WIDTH_64 = 2'd2;

  localparam int SymW   = 8;
  localparam int DigitW = 5;
  localparam int ValueW = 64;

  typedef struct packed {
    logic              is_digit;
    logic              is_skip;
    logic [DigitW-1:0] digit;
  } sym_class_t;

endpackage

`default_nettype wire

// File: sv/b32d_sym_decode.sv
// Byte classifier for the base32 decoder.
// Maps one text byte to a digit, a skip (hyphen) or a bad byte.
// Depends on b32d_pkg.
`default_nettype none

module b32d_sym_decode (
  input  wire logic [7:0]             sym,
  output b32d_pkg::sym_class_t        cls
);
  import b32d_pkg::*;

  logic [7:0] upper;

  always_comb begin
    upper = sym;
    if (sym >= 8'd97 && sym <= 8'd122) begin
      upper = sym - 8'd32;
    end
    cls.is_digit = 1'b1;
    cls.is_skip  = 1'b0;
    cls.digit    = '0;
    if (sym >= 8'd48 && sym <= 8'd57) begin
      cls.digit = DigitW'(sym - 8'd48);
    end else begin
      case (upper)
        8'h41: cls.digit = 5'd10;
        8'h42: cls.digit = 5'd11;
        8'h43: cls.digit = 5'd12;
        8'h44: cls.digit = 5'd13;
        8'h45: cls.digit = 5'd14;
        8'h46: cls.digit = 5'd15;
        8'h47: cls.digit = 5'd16;
        8'h48: cls.digit = 5'd17;
        8'h49: cls.digit = 5'd1;
        8'h4A: cls.digit = 5'd18;
        8'h4B: cls.digit = 5'd19;
        8'h4C: cls.digit = 5'd1;
        8'h4D: cls.digit = 5'd20;
        8'h4E: cls.digit = 5'd21;
        8'h4F: cls.digit = 5'd0;
        8'h50: cls.digit = 5'd22;
        8'h51: cls.digit = 5'd23;
        8'h52: cls.digit = 5'd24;
        8'h53: cls.digit = 5'd25;
        8'h54: cls.digit = 5'd26;
        8'h56: cls.digit = 5'd27;
        8'h57: cls.digit = 5'd28;
        8'h58: cls.digit = 5'd29;
        8'h59: cls.digit = 5'd30;
        8'h5A: cls.digit = 5'd31;
        8'h2D: begin
          cls.is_digit = 1'b0;
          cls.is_skip  = 1'b1;
        end
        default: cls.is_digit = 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/b32d_accum.sv
// String state and result formation for the base32 decoder.
// Holds accumulator, digit-seen flag and first error; forms the result
// at the terminator. Depends on b32d_pkg.
`default_nettype none

module b32d_accum (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 fire,
  input  wire logic                 is_term,
  input  wire b32d_pkg::sym_class_t cls,
  input  wire logic [1:0]           result_width,
  output logic [63:0]               res_value,
  output b32d_pkg::status_t         res_status
);
  import b32d_pkg::*;

  logic [ValueW-1:0] acc_r, acc_nxt;
  logic              seen_r, seen_nxt;
  status_t           err_r, err_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    seen_nxt = seen_r;
    err_nxt  = err_r;
    if (fire) begin
      if (is_term) begin
        acc_nxt  = '0;
        seen_nxt = 1'b0;
        err_nxt  = STATUS_OK;
      end else if (err_r == STATUS_OK) begin
        if (cls.is_digit) begin
          seen_nxt = 1'b1;
          if (acc_r[ValueW-1:ValueW-DigitW] != '0) begin
            err_nxt = STATUS_RANGE;
          end else begin
            acc_nxt = {acc_r[ValueW-DigitW-1:0], cls.digit};
          end
        end else if (!cls.is_skip) begin
          err_nxt = STATUS_INVALID;
        end
      end
    end
  end

  always_comb begin
    res_status = err_r;
    if (err_r == STATUS_OK) begin
      if (!seen_r) begin
        res_status = STATUS_INVALID;
      end else if (result_width == WIDTH_16 && acc_r[63:16] != '0) begin
        res_status = STATUS_RANGE;
      end else if (result_width == WIDTH_32 && acc_r[63:32] != '0) begin
        res_status = STATUS_RANGE;
      end
    end
    res_value = (res_status == STATUS_OK) ? acc_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      seen_r <= 1'b0;
      err_r  <= STATUS_OK;
    end else begin
      acc_r  <= acc_nxt;
      seen_r <= seen_nxt;
      err_r  <= err_nxt;
    end
  end

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_term |=> acc_r == '0 && !seen_r && err_r == STATUS_OK)
    else $error("string state not cleared after terminator");

  a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !is_term && err_r != STATUS_OK |=> $stable(err_r) && $stable(acc_r))
    else $error("state changed after first error");

  a_ok_needs_digit: assert property (@(posedge clk) disable iff (!rst_n)
    res_status == STATUS_OK |-> seen_r)
    else $error("ok status without any digit");

  a_value_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    res_status != STATUS_OK |-> res_value == '0)
    else $error("value not zero on error status");

endmodule

`default_nettype wire

// File: sv/base32_text_to_integer.sv
// Base32 text-to-integer decoder, top level.
// Input byte register, byte classifier, string state and result register.
// Depends on b32d_pkg, b32d_sym_decode and b32d_accum.
//
// Usage:
//   in_*  : one text byte per request in in_tdata. A zero byte ends the
//           string and yields exactly one result; other bytes yield none.
//   out_* : out_tdata carries the decoded value, zero unless status is ok;
//           out_tuser carries the status (0 ok, 1 invalid, 2 out of range).
//   cfg_* : cfg_data selects the result width (0: 16, 1: 32, 2 or 3: 64
//           bits). cfg_ready is always high; write only while idle.
// Timing: one byte per cycle sustained unless stalled. A byte is registered
//   on accept, then processed; a terminator's result is held in the result
//   register, which drives out_tvalid. The processing stage advances on any
//   byte but a terminator, which waits for the result register to be free;
//   with out_tready low and a result pending, at most one more terminator
//   and the bytes ahead of it are absorbed before in_tready drops.
// Reset: rst_n (synchronous, active low) clears the string state, empties
//   both registers and sets the width to 64 bits.
`default_nettype none

module base32_text_to_integer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] symbol
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] value
  output logic [7:0]       out_tuser,  // [1:0] status, [7:2] zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data    // [1:0] result_width
);
  import b32d_pkg::*;

  logic           s1_valid_r, s1_valid_nxt;
  logic [SymW-1:0] s1_sym_r;
  logic           s1_term, s1_adv, s1_fire, out_free, in_fire;
  logic [1:0]     width_r;
  logic           out_valid_r, out_valid_nxt;
  logic [63:0]    out_value_r;
  status_t        out_status_r;
  sym_class_t     cls;
  logic [63:0]    res_value;
  status_t        res_status;

  b32d_sym_decode u_dec (
    .sym (s1_sym_r),
    .cls (cls)
  );

  b32d_accum u_acc (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (s1_fire),
    .is_term      (s1_term),
    .cls          (cls),
    .result_width (width_r),
    .res_value    (res_value),
    .res_status   (res_status)
  );

  assign s1_term   = (s1_sym_r == '0);
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = !s1_term || out_free;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_term) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      width_r     <= WIDTH_64;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        width_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sym_r <= in_tdata;
    end
    if (s1_fire && s1_term) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = {6'd0, out_status_r};

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the base32 text-to-integer decoder.
// Streams byte strings under random stalls on both sides, predicts each result and checks it.
// Depends on b32d_pkg and base32_text_to_integer.
`timescale 1ns / 1ps

module testbench;
  import b32d_pkg::*;

  localparam logic [1:0] WIDTH_SPARE = 2'd3;
  localparam logic [7:0] TERMINATOR  = 8'h00;
  localparam logic [7:0] HYPHEN      = 8'h2D;
  localparam int PhaseItems  = 310;
  localparam int Phases      = 6;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 200000;
  localparam logic [1:0] WidthPlan [Phases] =
    '{WIDTH_64, WIDTH_16, WIDTH_32, WIDTH_SPARE, WIDTH_64, WIDTH_16};

  typedef struct {
    logic [63:0] value;
    status_t     status;
  } decode_result_t;

  class decode_scoreboard;
    string          digit_chars;
    sym_class_t     sym_map [256];
    logic [63:0]    accum;
    bit             seen_digit;
    status_t        first_error;
    logic [1:0]     width;
    decode_result_t pending [$];
    int             mismatches;
    int             checked;
    int             status_count [3];

    function new();
      sym_class_t c;
      digit_chars = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";
      for (int b = 0; b < 256; b++) sym_map[b] = '0;
      for (int d = 0; d < 32; d++) begin
        c = '{is_digit: 1'b1, is_skip: 1'b0, digit: d[4:0]};
        sym_map[digit_chars[d]] = c;
        if (digit_chars[d] >= "A") sym_map[digit_chars[d] + 32] = c;
      end
      sym_map["I"] = sym_map["1"];
      sym_map["i"] = sym_map["1"];
      sym_map["L"] = sym_map["1"];
      sym_map["l"] = sym_map["1"];
      sym_map["O"] = sym_map["0"];
      sym_map["o"] = sym_map["0"];
      sym_map[HYPHEN] = '{is_digit: 1'b0, is_skip: 1'b1, digit: 5'd0};
      width = WIDTH_64;
      clear_string();
    endfunction

    function void clear_string();
      accum       = '0;
      seen_digit  = 1'b0;
      first_error = STATUS_OK;
    endfunction

    function bit is_bad(logic [7:0] b);
      return !sym_map[b].is_digit && !sym_map[b].is_skip;
    endfunction

    // Returns 1 when the byte acts on the string state.
    function bit note_symbol(logic [7:0] b);
      sym_class_t     c;
      decode_result_t r;
      logic [68:0]    grown;
      if (b == TERMINATOR) begin
        r.status = first_error;
        if (r.status == STATUS_OK && !seen_digit) r.status = STATUS_INVALID;
        if (r.status == STATUS_OK &&
            ((width == WIDTH_16 && accum > 64'h0000_0000_0000_FFFF) ||
             (width == WIDTH_32 && accum > 64'h0000_0000_FFFF_FFFF)))
          r.status = STATUS_RANGE;
        r.value = (r.status == STATUS_OK) ? accum : '0;
        pending.push_back(r);
        clear_string();
        return 1'b1;
      end
      if (first_error != STATUS_OK) return 1'b0;
      c = sym_map[b];
      if (is_bad(b)) begin
        first_error = STATUS_INVALID;
      end else if (c.is_digit) begin
        seen_digit = 1'b1;
        grown = {accum, 5'b0} + c.digit;
        if (grown[68:64] != 0) first_error = STATUS_RANGE;
        else accum = grown[63:0];
      end
      return 1'b1;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic [63:0] value, logic [7:0] user);
      decode_result_t e;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result: value %h status %0d", value, user));
        return;
      end
      e = pending.pop_front();
      checked++;
      status_count[int'(e.status)]++;
      if (value !== e.value)
        flag($sformatf("value mismatch: expected %h got %h", e.value, value));
      if (user !== {6'b0, e.status})
        flag($sformatf("status mismatch: expected %0d got %0d", e.status, user));
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [7:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data   = '0;

  decode_scoreboard ledger = new();
  logic [7:0]       text_q [$];
  bit               in_burst;
  bit               out_burst;
  int               acted;
  int               sent;
  int               cycles;

  base32_text_to_integer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] symbol
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [63:0] value
    .out_tuser  (out_tuser),  // [1:0] status, [7:2] zero
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)    // [1:0] result_width
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               ledger.pending.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [7:0] spell_digit(logic [4:0] d);
    logic [7:0] ch;
    ch = ledger.digit_chars[d];
    case ($urandom_range(0, 3))
      0: if (d == 5'd1) ch = "I"; else if (d == 5'd0) ch = "O";
      1: if (d == 5'd1) ch = "L";
      default: ;
    endcase
    if (ch >= "A" && $urandom_range(0, 1) == 1) ch = ch + 8'd32;
    return ch;
  endfunction

  function automatic void put(logic [7:0] ch);
    if ($urandom_range(0, 7) == 0) text_q.push_back(HYPHEN);
    text_q.push_back(ch);
  endfunction

  function automatic void put_text(string s);
    for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
    text_q.push_back(TERMINATOR);
  endfunction

  function automatic void add_value(logic [63:0] v, int extra_digits);
    logic [64:0] w;
    int          top;
    w   = {1'b0, v};
    top = 12;
    while (top > 0 && w[5*top +: 5] == 0) top--;
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3)) put(spell_digit(5'd0));
    for (int k = top; k >= 0; k--) put(spell_digit(w[5*k +: 5]));
    repeat (extra_digits) put(spell_digit(5'($urandom_range(0, 31))));
    if ($urandom_range(0, 15) == 0) text_q.push_back(HYPHEN);
  endfunction

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(0, 6))
      0: v = 64'h1_0000 + 64'($urandom_range(0, 6)) - 64'd3;
      1: v = 64'h1_0000_0000 + 64'($urandom_range(0, 6)) - 64'd3;
      2: v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
      3: v = 64'($urandom_range(0, 1023));
      4: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      5: v = 64'($urandom_range(0, 65535));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pick_bad();
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 1) == 1) ? "U" : "u";
    do b = 8'($urandom_range(1, 255)); while (!ledger.is_bad(b));
    return b;
  endfunction

  function automatic void build_string();
    int          kind;
    logic [63:0] v;
    kind = $urandom_range(0, 15);
    if (kind <= 10) begin
      add_value(pick_value(), 0);
    end else if (kind == 11) begin
      v = {$urandom, $urandom} | (64'h1 << $urandom_range(59, 63));
      add_value(v, $urandom_range(1, 2));
      if ($urandom_range(0, 1) == 1) text_q.push_back(pick_bad());
    end else if (kind == 12) begin
      add_value(pick_value(), 0);
      text_q.insert($urandom_range(0, text_q.size()), pick_bad());
    end else if (kind == 13) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 14) begin
      repeat ($urandom_range(0, 3)) text_q.push_back(HYPHEN);
    end else begin
      add_value(64'($urandom_range(0, 31)), 0);
    end
    text_q.push_back(TERMINATOR);
  endfunction

  task automatic send_symbol(input logic [7:0] sym);
    int gap;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    do @(posedge clk); while (!in_tready);
    if (ledger.note_symbol(sym)) acted++;
    sent++;
  endtask

  task automatic send_text();
    while (text_q.size() > 0) send_symbol(text_q.pop_front());
  endtask

  // Drop valid, drain every pending result, then let the pipeline empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_width(input logic [1:0] w);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ledger.width = w;
  endtask

  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      ledger.check_result(out_tdata, out_tuser);
    end
  end

  initial begin : stimulus
    int phase_start;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_text("");
    put_text("-");
    text_q.push_back(8'hFF);
    put_text("7");
    put_text("iLo");
    put_text("U");
    put_text("zZZZZZZZZZZZZ");
    send_text();

    for (int p = 0; p < Phases; p++) begin
      if (p > 0) begin
        settle();
        write_width(WidthPlan[p]);
      end
      phase_start = acted;
      while (acted - phase_start < PhaseItems) begin
        build_string();
        send_text();
      end
    end
    settle();

    $display("sent %0d bytes (%0d acting), checked %0d strings: %0d ok, %0d invalid, %0d range",
             sent, acted, ledger.checked, ledger.status_count[0], ledger.status_count[1],
             ledger.status_count[2]);
    $display("width modes 64, 16, 32, spare code, 64, 16; %0d mismatches in %0d cycles",
             ledger.mismatches, cycles);
    if (ledger.mismatches == 0 && ledger.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
